/* sv/psrl_pkg.sv */
`default_nettype none
package psrl_pkg;

    localparam int SENDER_ENTRIES   = 256;
    localparam int OVERRIDE_ENTRIES = 16;

    localparam int SIDX_W = (SENDER_ENTRIES > 1) ? $clog2(SENDER_ENTRIES) : 1;
    localparam int FILL_W = $clog2(SENDER_ENTRIES + 1);
    localparam int OIDX_W = (OVERRIDE_ENTRIES > 1) ? $clog2(OVERRIDE_ENTRIES) : 1;

    localparam int KEY_W   = 64;
    localparam int DATA_W  = 32;
    localparam int ENTRY_W = KEY_W + 2 * DATA_W;

    localparam logic [1:0] REQ_CHECK    = 2'd0;
    localparam logic [1:0] REQ_OVERRIDE = 2'd1;
    localparam logic [1:0] REQ_CLEAR    = 2'd2;

    localparam logic [2:0] ST_ALLOWED  = 3'd0;
    localparam logic [2:0] ST_LIMITED  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_OVR_DONE = 3'd3;
    localparam logic [2:0] ST_OVR_NOT  = 3'd4;

    localparam logic [2:0] CL_CHECK   = 3'd0;
    localparam logic [2:0] CL_NOKEY   = 3'd1;
    localparam logic [2:0] CL_OVR     = 3'd2;
    localparam logic [2:0] CL_OVR_NOT = 3'd3;
    localparam logic [2:0] CL_CLEAR   = 3'd4;

    localparam logic CFG_DEFAULT_MAX    = 1'b0;
    localparam logic CFG_DEFAULT_WINDOW = 1'b1;

    typedef struct packed {
        logic [2:0]        cls;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] now;
        logic [DATA_W-1:0] omax;
        logic [DATA_W-1:0] owin;
    } t_cmd;

    typedef struct packed {
        logic [2:0]        status;
        logic [DATA_W-1:0] allowed;
        logic [DATA_W-1:0] dropped;
    } t_res;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] start;
        logic [DATA_W-1:0] count;
    } t_entry;

endpackage
`default_nettype wire

/* sv/psrl_ram.sv */
`default_nettype none
module psrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                            i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                            o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* sv/psrl_front.sv */
`default_nettype none
module psrl_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    output logic                      o_full,
    input  wire logic [1:0]           i_req_type,
    input  wire logic                 i_has_key,
    input  wire logic [63:0]          i_source_key,
    input  wire logic [31:0]          i_now,
    input  wire logic [31:0]          i_override_max,
    input  wire logic [31:0]          i_override_window,
    output logic                      o_cmd_valid,
    output psrl_pkg::t_cmd            o_cmd,
    input  wire logic                 i_cmd_pop
);
    psrl_pkg::t_cmd r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    psrl_pkg::t_cmd w_cmd;
    logic           w_push, w_pop;

    always_comb begin
        w_cmd.key  = i_source_key;
        w_cmd.now  = i_now;
        w_cmd.omax = i_override_max;
        w_cmd.owin = i_override_window;
        case (i_req_type)
            psrl_pkg::REQ_CHECK:
                w_cmd.cls = i_has_key ? psrl_pkg::CL_CHECK : psrl_pkg::CL_NOKEY;
            psrl_pkg::REQ_OVERRIDE:
                w_cmd.cls = (i_has_key && i_override_max != '0) ?
                            psrl_pkg::CL_OVR : psrl_pkg::CL_OVR_NOT;
            psrl_pkg::REQ_CLEAR:
                w_cmd.cls = psrl_pkg::CL_CLEAR;
            default:
                w_cmd.cls = psrl_pkg::CL_OVR_NOT;
        endcase
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_push && !o_full;
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule
`default_nettype wire

/* sv/psrl_back.sv */
`default_nettype none
module psrl_back (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_cmd_valid,
    input  wire psrl_pkg::t_cmd i_cmd,
    output logic             o_cmd_pop,
    output logic             o_empty,
    input  wire logic        i_pop,
    output psrl_pkg::t_res   o_res
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LKP  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;
    localparam logic [2:0] S_RESP = 3'd5;

    logic [2:0]                    r_state;
    psrl_pkg::t_cmd                r_cmd;
    logic [psrl_pkg::FILL_W-1:0]   r_idx, r_fill;
    logic [31:0]                   r_lim, r_win, r_start, r_count;
    logic                          r_new;
    psrl_pkg::t_res                r_res;
    logic [31:0]                   r_allowed, r_dropped, r_dmax, r_dwin;

    logic [psrl_pkg::OVERRIDE_ENTRIES-1:0] r_ovr_valid;
    logic [63:0] r_ovr_key  [psrl_pkg::OVERRIDE_ENTRIES];
    logic [31:0] r_ovr_lim  [psrl_pkg::OVERRIDE_ENTRIES];
    logic [31:0] r_ovr_span [psrl_pkg::OVERRIDE_ENTRIES];

    psrl_pkg::t_res r_oq [2];
    logic           r_owp, r_orp;
    logic [1:0]     r_ocnt;

    logic                         w_hit, w_free;
    logic [psrl_pkg::OIDX_W-1:0]  w_hit_idx, w_free_idx, w_sel;
    psrl_pkg::t_entry             w_rd, w_wr;
    logic                         w_we, w_restart, w_oq_push, w_oq_pop;
    logic [32:0]                  w_end;
    logic [31:0]                  w_st, w_ct;

    always_comb begin
        w_hit = 1'b0;
        w_free = 1'b0;
        w_hit_idx = '0;
        w_free_idx = '0;
        for (int i = psrl_pkg::OVERRIDE_ENTRIES - 1; i >= 0; i--) begin
            if (r_ovr_valid[i] && r_ovr_key[i] == r_cmd.key) begin
                w_hit = 1'b1;
                w_hit_idx = psrl_pkg::OIDX_W'(i);
            end
            if (!r_ovr_valid[i]) begin
                w_free = 1'b1;
                w_free_idx = psrl_pkg::OIDX_W'(i);
            end
        end
        w_sel = w_hit ? w_hit_idx : w_free_idx;
    end

    assign w_end     = {1'b0, r_start} + {1'b0, r_win};
    assign w_restart = {1'b0, r_cmd.now} >= w_end;
    assign w_st      = w_restart ? r_cmd.now : r_start;
    assign w_ct      = w_restart ? '0 : r_count;
    assign w_we      = (r_state == S_UPD);
    assign w_wr.key  = r_cmd.key;
    assign w_wr.start = w_st;
    assign w_wr.count = (r_lim != '0 && w_ct < r_lim) ? w_ct + 32'd1 : w_ct;

    psrl_ram #(
        .WIDTH (psrl_pkg::ENTRY_W),
        .DEPTH (psrl_pkg::SENDER_ENTRIES)
    ) u_sender_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_idx[psrl_pkg::SIDX_W-1:0]),
        .i_wdata (w_wr),
        .i_raddr (r_idx[psrl_pkg::SIDX_W-1:0]),
        .o_rdata (w_rd)
    );

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;
    assign o_empty   = (r_ocnt == 2'd0);
    assign o_res     = r_oq[r_orp];
    assign w_oq_push = (r_state == S_RESP) && (r_ocnt != 2'd2);
    assign w_oq_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_oq_push) begin
            r_oq[r_owp] <= r_res;
        end
        case (r_state)
            S_IDLE: begin
                r_cmd <= i_cmd;
                r_res.allowed <= r_allowed;
                r_res.dropped <= r_dropped;
                case (i_cmd.cls)
                    psrl_pkg::CL_NOKEY: r_res.status <= psrl_pkg::ST_ALLOWED;
                    psrl_pkg::CL_CLEAR: r_res.status <= psrl_pkg::ST_OVR_DONE;
                    default:            r_res.status <= psrl_pkg::ST_OVR_NOT;
                endcase
            end
            S_LKP: begin
                r_lim <= w_hit ? r_ovr_lim[w_hit_idx]  : r_dmax;
                r_win <= w_hit ? r_ovr_span[w_hit_idx] : r_dwin;
                if (r_cmd.cls == psrl_pkg::CL_OVR) begin
                    if (w_hit || w_free) begin
                        r_ovr_key[w_sel]  <= r_cmd.key;
                        r_ovr_lim[w_sel]  <= r_cmd.omax;
                        r_ovr_span[w_sel] <= r_cmd.owin;
                        r_res.status <= psrl_pkg::ST_OVR_DONE;
                    end
                end
            end
            S_RD: begin
                if (r_idx == r_fill) begin
                    r_new   <= 1'b1;
                    r_start <= r_cmd.now;
                    r_count <= '0;
                    if (r_fill == psrl_pkg::FILL_W'(psrl_pkg::SENDER_ENTRIES)) begin
                        r_res.status <= psrl_pkg::ST_FULL;
                    end
                end
            end
            S_CMP: begin
                r_new   <= 1'b0;
                r_start <= w_rd.start;
                r_count <= w_rd.count;
            end
            S_UPD: begin
                if (r_lim == '0 || w_ct < r_lim) begin
                    r_res.status  <= psrl_pkg::ST_ALLOWED;
                    r_res.allowed <= r_allowed + 32'd1;
                end else begin
                    r_res.status  <= psrl_pkg::ST_LIMITED;
                    r_res.dropped <= r_dropped + 32'd1;
                end
            end
            default: begin
            end
        endcase

        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_fill      <= '0;
            r_allowed   <= '0;
            r_dropped   <= '0;
            r_dmax      <= '0;
            r_dwin      <= 32'd1;
            r_ovr_valid <= '0;
            r_owp       <= 1'b0;
            r_orp       <= 1'b0;
            r_ocnt      <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    psrl_pkg::CFG_DEFAULT_MAX:    r_dmax <= i_cfg_data;
                    psrl_pkg::CFG_DEFAULT_WINDOW: r_dwin <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (w_oq_push) r_owp <= ~r_owp;
            if (w_oq_pop)  r_orp <= ~r_orp;
            r_ocnt <= r_ocnt + {1'b0, w_oq_push} - {1'b0, w_oq_pop};

            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_idx <= '0;
                        if (i_cmd.cls == psrl_pkg::CL_CHECK ||
                            i_cmd.cls == psrl_pkg::CL_OVR) begin
                            r_state <= S_LKP;
                        end else begin
                            if (i_cmd.cls == psrl_pkg::CL_CLEAR) r_ovr_valid <= '0;
                            r_state <= S_RESP;
                        end
                    end
                end
                S_LKP: begin
                    if (r_cmd.cls == psrl_pkg::CL_OVR) begin
                        if (w_hit || w_free) r_ovr_valid[w_sel] <= 1'b1;
                        r_state <= S_RESP;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    if (r_idx == r_fill) begin
                        if (r_fill == psrl_pkg::FILL_W'(psrl_pkg::SENDER_ENTRIES))
                            r_state <= S_RESP;
                        else
                            r_state <= S_UPD;
                    end else begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (w_rd.key == r_cmd.key) begin
                        r_state <= S_UPD;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_UPD: begin
                    if (r_new) r_fill <= r_fill + 1'b1;
                    if (r_lim == '0 || w_ct < r_lim) r_allowed <= r_allowed + 32'd1;
                    else r_dropped <= r_dropped + 32'd1;
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (r_ocnt != 2'd2) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* sv/per_source_rate_limiter_top.sv */
`default_nettype none
// Per-source fixed-window rate limiter. Words enter through a two-word
// command queue and results leave through a two-word result queue, so both
// sides may stall freely. Clears, checks without a key, invalid requests
// and override writes without a key or with a zero limit go from idle
// straight to response; other override writes pass the override lookup
// first. A keyed check scans the sender table in allocation order, one RAM
// read and one key compare per known source, so that scan sets the rate.
// Override lookup is parallel over its 16 entries. Sender entries are never
// freed. The user must write defaults through the cfg port while idle; the
// block itself does not enforce this.
module per_source_rate_limiter_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  i_req_type,
    input  wire logic        i_has_key,
    input  wire logic [63:0] i_source_key,
    input  wire logic [31:0] i_now,
    input  wire logic [31:0] i_override_max,
    input  wire logic [31:0] i_override_window,
    output logic             empty,
    input  wire logic        pop,
    output logic [2:0]       o_status,
    output logic [31:0]      o_allowed_total,
    output logic [31:0]      o_dropped_total
);
    logic           w_cmd_valid, w_cmd_pop;
    psrl_pkg::t_cmd w_cmd;
    psrl_pkg::t_res w_res;

    psrl_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (push),
        .o_full            (full),
        .i_req_type        (i_req_type),
        .i_has_key         (i_has_key),
        .i_source_key      (i_source_key),
        .i_now             (i_now),
        .i_override_max    (i_override_max),
        .i_override_window (i_override_window),
        .o_cmd_valid       (w_cmd_valid),
        .o_cmd             (w_cmd),
        .i_cmd_pop         (w_cmd_pop)
    );

    psrl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_res       (w_res)
    );

    assign o_status        = w_res.status;
    assign o_allowed_total = w_res.allowed;
    assign o_dropped_total = w_res.dropped;
endmodule
`default_nettype wire

/* sv/psrl_checker.sv */
`default_nettype none
module psrl_sva (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        full,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [2:0]  o_status,
    input wire logic [31:0] o_allowed_total,
    input wire logic [31:0] o_dropped_total
);
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_rst_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("command queue full after reset");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_status <= psrl_pkg::ST_OVR_NOT))
        else $error("status code out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_status) &&
        $stable(o_allowed_total) && $stable(o_dropped_total)))
        else $error("result word changed while stalled");
endmodule

bind per_source_rate_limiter_top psrl_sva u_psrl_sva (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .full            (full),
    .empty           (empty),
    .pop             (pop),
    .o_status        (o_status),
    .o_allowed_total (o_allowed_total),
    .o_dropped_total (o_dropped_total)
);
`default_nettype wire
